### rtl/core/nmct_pkg.sv
// ----------------------------------------------------------------------------
// nmct_pkg
// types, sizes and message kind codes shared by the neighbor counter table
// ----------------------------------------------------------------------------
package nmct_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int CNT_W       = 32;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] KIND_DIO  = 2'd0;
    localparam logic [CMD_W-1:0] KIND_DAO  = 2'd1;
    localparam logic [CMD_W-1:0] KIND_DIS  = 2'd2;
    localparam logic [CMD_W-1:0] KIND_NONE = 2'd3;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [USED_W-1:0] t_used;

    typedef struct packed {
        t_count count_dio;
        t_count count_dao;
        t_count count_dis;
    } t_counts;

    typedef struct packed {
        t_addr   addr_high;
        t_addr   addr_low;
        t_counts counts;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_cmd  cmd;
        t_addr addr_high;
        t_addr addr_low;
    } t_req;

    typedef struct packed {
        t_index entry_index;
        logic   was_new;
        logic   table_full;
        t_count count_dio;
        t_count count_dao;
        t_count count_dis;
        t_used  entries_used;
    } t_result;

endpackage

### rtl/core/nmct_if.sv
// ----------------------------------------------------------------------------
// nmct_if
// valid/ready channels for event words in and result words out
// ----------------------------------------------------------------------------
interface nmct_req_if;
    logic                 valid;
    logic                 ready;
    nmct_pkg::t_cmd       cmd;
    nmct_pkg::t_addr      addr_high;
    nmct_pkg::t_addr      addr_low;

    modport source (output valid, output cmd, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input cmd, input addr_high, input addr_low,
                    output ready);
endinterface

interface nmct_rsp_if;
    logic                 valid;
    logic                 ready;
    nmct_pkg::t_index     entry_index;
    logic                 was_new;
    logic                 table_full;
    nmct_pkg::t_count     count_dio;
    nmct_pkg::t_count     count_dao;
    nmct_pkg::t_count     count_dis;
    nmct_pkg::t_used      entries_used;

    modport source (output valid, output entry_index, output was_new,
                    output table_full, output count_dio, output count_dao,
                    output count_dis, output entries_used, input ready);
    modport sink   (input valid, input entry_index, input was_new,
                    input table_full, input count_dio, input count_dao,
                    input count_dis, input entries_used, output ready);
endinterface

### rtl/core/nmct_ram.sv
// ----------------------------------------------------------------------------
// nmct_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module nmct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/nmct_seq.sv
// ----------------------------------------------------------------------------
// nmct_seq
// search sequencer: walks the used slots one per cycle through the slot ram,
// one 128-bit compare and one shared counter incrementer
// ----------------------------------------------------------------------------
module nmct_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  nmct_pkg::t_req    i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output nmct_pkg::t_result o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MISS = 2'd2;
    localparam logic [1:0] S_HAND = 2'd3;

    logic [1:0]        r_state, n_state;
    nmct_pkg::t_cmd    r_cmd, n_cmd;
    nmct_pkg::t_addr   r_hi, n_hi;
    nmct_pkg::t_addr   r_lo, n_lo;
    nmct_pkg::t_index  r_idx, n_idx;
    nmct_pkg::t_used   r_used, n_used;
    nmct_pkg::t_result r_res, n_res;

    logic              w_rd_en;
    nmct_pkg::t_index  w_rd_addr;
    logic              w_wr_en;
    nmct_pkg::t_index  w_wr_addr;
    nmct_pkg::t_entry  w_wr_data;
    nmct_pkg::t_entry  w_rd_data;

    logic              w_match;
    logic              w_hit;
    logic              w_last;
    logic              w_known;
    nmct_pkg::t_counts w_base;
    nmct_pkg::t_count  w_sel;
    nmct_pkg::t_count  w_inc;
    nmct_pkg::t_counts w_new;
    nmct_pkg::t_result w_miss_res;
    logic              w_miss_wr;
    nmct_pkg::t_used   w_miss_used;

    nmct_ram #(
        .WIDTH (nmct_pkg::ENTRY_W),
        .DEPTH (nmct_pkg::TABLE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // read data belongs to slot r_idx while scanning
    assign w_match = (w_rd_data.addr_high == r_hi) && (w_rd_data.addr_low == r_lo);
    assign w_hit   = (r_state == S_SCAN) && w_match;
    assign w_last  = (nmct_pkg::t_used'(r_idx) + nmct_pkg::t_used'(1)) == r_used;
    assign w_known = (r_cmd == nmct_pkg::KIND_DIO) || (r_cmd == nmct_pkg::KIND_DAO)
                  || (r_cmd == nmct_pkg::KIND_DIS);

    // shared incrementer: old counts on a hit, zero for a fresh slot
    always_comb begin
        w_base = w_hit ? w_rd_data.counts : '0;
        case (r_cmd)
            nmct_pkg::KIND_DIO: w_sel = w_base.count_dio;
            nmct_pkg::KIND_DAO: w_sel = w_base.count_dao;
            nmct_pkg::KIND_DIS: w_sel = w_base.count_dis;
            default:            w_sel = '0;
        endcase
        w_inc = w_sel + nmct_pkg::t_count'(1);
        w_new = w_base;
        case (r_cmd)
            nmct_pkg::KIND_DIO: w_new.count_dio = w_inc;
            nmct_pkg::KIND_DAO: w_new.count_dao = w_inc;
            nmct_pkg::KIND_DIS: w_new.count_dis = w_inc;
            default:            w_new = w_base;
        endcase
    end

    // outcome when no used slot matched
    always_comb begin
        w_miss_res  = '0;
        w_miss_wr   = 1'b0;
        w_miss_used = r_used;
        if (w_known) begin
            if (r_used == nmct_pkg::t_used'(nmct_pkg::TABLE_DEPTH)) begin
                w_miss_res.table_full = 1'b1;
            end else begin
                w_miss_wr              = 1'b1;
                w_miss_used            = r_used + nmct_pkg::t_used'(1);
                w_miss_res.entry_index = r_used[nmct_pkg::IDX_W-1:0];
                w_miss_res.was_new     = 1'b1;
                w_miss_res.count_dio   = w_new.count_dio;
                w_miss_res.count_dao   = w_new.count_dao;
                w_miss_res.count_dis   = w_new.count_dis;
            end
        end
        w_miss_res.entries_used = w_miss_used;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_idx     = r_idx;
        n_used    = r_used;
        n_res     = r_res;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = '{addr_high: r_hi, addr_low: r_lo, counts: w_new};
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd = i_req.cmd;
                    n_hi  = i_req.addr_high;
                    n_lo  = i_req.addr_low;
                    n_idx = '0;
                    if (r_used == '0) begin
                        n_state = S_MISS;
                    end else begin
                        w_rd_en = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    w_wr_en            = w_known;
                    n_res              = '0;
                    n_res.entry_index  = r_idx;
                    n_res.count_dio    = w_new.count_dio;
                    n_res.count_dao    = w_new.count_dao;
                    n_res.count_dis    = w_new.count_dis;
                    n_res.entries_used = r_used;
                    n_state            = S_HAND;
                end else if (!w_last) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx + nmct_pkg::t_index'(1);
                    n_idx     = r_idx + nmct_pkg::t_index'(1);
                end else begin
                    w_wr_en   = w_miss_wr;
                    w_wr_addr = r_used[nmct_pkg::IDX_W-1:0];
                    n_used    = w_miss_used;
                    n_res     = w_miss_res;
                    n_state   = S_HAND;
                end
            end
            S_MISS: begin
                w_wr_en   = w_miss_wr;
                w_wr_addr = r_used[nmct_pkg::IDX_W-1:0];
                n_used    = w_miss_used;
                n_res     = w_miss_res;
                n_state   = S_HAND;
            end
            S_HAND: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_cmd <= n_cmd;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HAND);
    assign o_res       = r_res;

endmodule

### rtl/core/neighbor_message_counter_table_unit.sv
// ----------------------------------------------------------------------------
// neighbor_message_counter_table_unit
// per-sender counters of DIO, DAO and DIS routing control messages
// ----------------------------------------------------------------------------
// i_req carries one event word: message kind and 128-bit sender address as
// two 64-bit halves. o_rsp returns one result word per event: slot index,
// new-entry and table-full flags, the slot's three counts after the update
// (all zero when no slot matched or was added) and the number of slots in use.
// The used slots sit in a 16-entry ram and are read one per cycle, from slot
// 0, against a single 128-bit comparator; the first match is taken, a miss of
// a known kind appends a slot while one is free. An event passes through the
// accept state, the slot reads (or the miss state when no slot is in use)
// and a hand-off state into the output register, which drives o_rsp.
// i_req.ready is low from the accept until the result is handed off. A
// stalled o_rsp holds its word; the sequencer can finish the next event
// meanwhile and then waits in its hand-off state. Reset empties the table
// (slot count to zero) at once; slot contents need no clearing since only
// used slots are read.
// ----------------------------------------------------------------------------
module neighbor_message_counter_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nmct_req_if.sink   i_req,
    nmct_rsp_if.source o_rsp
);

    nmct_pkg::t_req    w_req;
    logic              w_res_valid;
    logic              w_res_ready;
    nmct_pkg::t_result w_res;

    logic              r_out_valid;
    nmct_pkg::t_result r_out;

    assign w_req = '{cmd: i_req.cmd, addr_high: i_req.addr_high, addr_low: i_req.addr_low};

    nmct_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register lets the sequencer go on while the receiver stalls; it takes a result when empty or being read
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.entry_index  = r_out.entry_index;
    assign o_rsp.was_new      = r_out.was_new;
    assign o_rsp.table_full   = r_out.table_full;
    assign o_rsp.count_dio    = r_out.count_dio;
    assign o_rsp.count_dao    = r_out.count_dao;
    assign o_rsp.count_dis    = r_out.count_dis;
    assign o_rsp.entries_used = r_out.entries_used;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entries_used <= 5'(nmct_pkg::TABLE_DEPTH)))
        else $error("slot count beyond table depth");

    a_new_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.was_new && o_rsp.table_full))
        else $error("word flagged both new and full");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.was_new) |->
        ((o_rsp.count_dio + o_rsp.count_dao + o_rsp.count_dis) == 32'd1))
        else $error("new slot does not hold a single count");

    a_busy_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && w_res_valid))
        else $error("sequencer takes a word while holding a result");
`endif

endmodule
